// ----- rtl/pwl_pkg.sv -----
// Shared types and constants for the piecewise-linear waveform generator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pwl_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Input command codes.
   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_SAMPLE = 3'd2,
      CMD_START  = 3'd3,
      CMD_STEP   = 3'd4
   } cmd_type;

   localparam logic [31:0] SWEEP_STEP_RESET = 32'd65536;

   // Register address (byte address 4*index, word select only).
   localparam logic [1:0] REG_SWEEP_STEP = 2'd0;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;        // capture the input word
      logic append;      // write the table at point_count
      logic clear;       // clear point_count
      logic start;       // load sweep_time
      logic sweep_adv;   // add step to sweep_time
      logic mod_start;   // begin reduction
      logic scan_start;  // begin segment search
      logic div_start;   // begin interpolation divide
      logic finish;      // form the result word
   } ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_full;
      logic is_empty;
      logic mod_done;
      logic scan_done;
      logic div_done;
   } sts_type;

endpackage

// ----- rtl/pwl_ctrl.sv -----
// Controller state machine of the waveform generator.
// Depends on pwl_pkg for the command and status structs.
`timescale 1ns / 1ps

module pwl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [2:0]       in_cmd,
   output logic             in_ready,
   input  logic             out_busy,
   output pwl_pkg::ctl_type ctl,
   input  pwl_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_MOD, S_SCAN, S_DIV, S_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [2:0]      cmd_ff, cmd_in;

   assign in_ready = (state_ff == S_IDLE);

   // Next state and command strobes.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               ctl.load = 1'b1;
               cmd_in   = in_cmd;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (cmd_ff)
               pwl_pkg::CMD_CLEAR: begin
                  ctl.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               pwl_pkg::CMD_APPEND: begin
                  if (sts.is_full) begin
                     if (!out_busy) begin
                        ctl.finish = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     ctl.append = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               pwl_pkg::CMD_START: begin
                  ctl.start = 1'b1;
                  state_in  = S_IDLE;
               end
               pwl_pkg::CMD_SAMPLE, pwl_pkg::CMD_STEP: begin
                  ctl.sweep_adv = (cmd_ff == pwl_pkg::CMD_STEP);
                  if (sts.is_empty) begin
                     state_in = S_EMIT;
                  end else begin
                     ctl.mod_start = 1'b1;
                     state_in      = S_MOD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MOD: begin
            if (sts.mod_done) begin
               ctl.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               ctl.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_busy) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

`ifndef SYNTHESIS
   // A word is only accepted while idle.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> state_ff == S_IDLE) else $error("load outside idle");
   // A result is only formed when the output is free.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> !out_busy) else $error("finish while output busy");
   // After a load the next cycle decodes.
   a_load_decode: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> state_ff == S_DECODE) else $error("load not followed by decode");
`endif

endmodule

// ----- rtl/pwl_datapath.sv -----
// Datapath of the waveform generator: breakpoint table, sweep accumulator,
// modulo unit, segment search and restoring divider. Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_datapath (
   input  logic             clock,
   input  logic             reset,
   input  pwl_pkg::ctl_type ctl,
   output pwl_pkg::sts_type sts,
   input  logic [2:0]       in_cmd,
   input  logic [30:0]      in_ptime,
   input  logic [15:0]      in_pval,
   input  logic [31:0]      in_time,
   input  logic [30:0]      sweep_step,
   output logic [31:0]      res_time,
   output logic [15:0]      res_value,
   output logic             res_empty,
   output logic             res_full
);

   localparam int IW = pwl_pkg::IDX_W;
   localparam int CW = pwl_pkg::CNT_W;

   // Breakpoint memories.
   logic [30:0] times_mem [pwl_pkg::MAX_POINTS];
   logic [15:0] vals_mem  [pwl_pkg::MAX_POINTS];

   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   sweep_ff, sweep_in;
   logic [30:0]   ptime_ff;
   logic [15:0]   pval_ff;
   logic [31:0]   samp_ff, samp_in;
   logic [2:0]    cmd_ff;

   // Table read port, registered data.
   logic [IW-1:0] rd_addr;
   logic [30:0]   rd_time_ff;
   logic [15:0]   rd_val_ff;

   assign sts.is_full  = (count_ff == CW'(pwl_pkg::MAX_POINTS));
   assign sts.is_empty = (count_ff == '0);

   // Input capture and table write.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= in_cmd;
         ptime_ff <= in_ptime;
         pval_ff  <= in_pval;
         samp_ff  <= in_time;
      end else begin
         samp_ff  <= samp_in;
      end
      if (ctl.append) begin
         times_mem[count_ff[IW-1:0]] <= ptime_ff;
         vals_mem[count_ff[IW-1:0]]  <= pval_ff;
      end
      rd_time_ff <= times_mem[rd_addr];
      rd_val_ff  <= vals_mem[rd_addr];
   end

   // Sample time is the sweep time for a sweep step.
   always_comb begin
      samp_in = samp_ff;
      if (ctl.mod_start || (ctl.sweep_adv))
         samp_in = (cmd_ff == pwl_pkg::CMD_STEP) ? sweep_ff : samp_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.clear)  count_in = '0;
      if (ctl.append) count_in = count_ff + CW'(1);
      sweep_in = sweep_ff;
      if (ctl.start)     sweep_in = samp_ff;
      if (ctl.sweep_adv) sweep_in = sweep_ff + {1'b0, sweep_step};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         count_ff <= count_in;
         sweep_ff <= sweep_in;
      end
   end

   // Modulo unit: restoring, one bit a cycle over 32 bits of |t|.
   // Period read first through the registered read port, then 32 steps.
   typedef enum logic [1:0] {M_IDLE, M_RD, M_RUN, M_FIX} mstate_type;
   mstate_type  m_st_ff;
   logic [5:0]  m_cnt_ff;
   logic [31:0] m_dvd_ff;   // magnitude shifting out
   logic [31:0] m_rem_ff;   // partial remainder
   logic [30:0] period_ff;
   logic        m_neg_ff;
   logic [30:0] tr_ff;
   logic        m_done_ff;
   logic [32:0] m_trial;

   assign m_trial = {m_rem_ff, m_dvd_ff[31]} - {2'b0, period_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         m_st_ff   <= M_IDLE;
         m_done_ff <= 1'b0;
      end else begin
         m_done_ff <= 1'b0;
         unique case (m_st_ff)
            M_IDLE: if (ctl.mod_start) m_st_ff <= M_RD;
            M_RD: begin
               m_st_ff <= M_RUN;
            end
            M_RUN: if (m_cnt_ff == 6'd31) m_st_ff <= M_FIX;
            M_FIX: begin
               m_st_ff   <= M_IDLE;
               m_done_ff <= 1'b1;
            end
            default: m_st_ff <= M_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (m_st_ff)
         M_RD: begin
            period_ff <= rd_time_ff;
            m_neg_ff  <= samp_ff[31];
            m_dvd_ff  <= samp_ff[31] ? (~samp_ff + 32'd1) : samp_ff;
            m_rem_ff  <= '0;
            m_cnt_ff  <= '0;
         end
         M_RUN: begin
            m_cnt_ff <= m_cnt_ff + 6'd1;
            m_dvd_ff <= {m_dvd_ff[30:0], 1'b0};
            if (!m_trial[32]) m_rem_ff <= m_trial[31:0];
            else              m_rem_ff <= {m_rem_ff[30:0], m_dvd_ff[31]};
         end
         M_FIX: begin
            if (period_ff == '0)
               tr_ff <= '0;
            else if (m_neg_ff && m_rem_ff != '0)
               tr_ff <= period_ff - m_rem_ff[30:0];
            else
               tr_ff <= m_rem_ff[30:0];
         end
         default: ;
      endcase
   end

   // Segment search: reads the table one entry at a time through the read port.
   typedef enum logic [2:0] {K_IDLE, K_RD, K_CHK, K_LO, K_LOW, K_DONE} kstate_type;
   kstate_type     k_st_ff;
   logic [IW-1:0]  k_idx_ff;
   logic [30:0]    hi_t_ff, lo_t_ff;
   logic [15:0]    hi_v_ff, lo_v_ff;
   logic           k_done_ff;
   logic [IW-1:0]  last_idx;

   assign last_idx = IW'(count_ff - CW'(1));

   always_comb begin
      rd_addr = k_idx_ff;
      if (m_st_ff == M_IDLE && ctl.mod_start) rd_addr = last_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_st_ff   <= K_IDLE;
         k_done_ff <= 1'b0;
         k_idx_ff  <= '0;
      end else begin
         k_done_ff <= 1'b0;
         unique case (k_st_ff)
            K_IDLE: if (ctl.scan_start) begin
               k_idx_ff <= '0;
               k_st_ff  <= K_RD;
            end
            K_RD: k_st_ff <= K_CHK;
            K_CHK: begin
               if (rd_time_ff >= tr_ff || k_idx_ff == last_idx) begin
                  hi_t_ff <= rd_time_ff;
                  hi_v_ff <= rd_val_ff;
                  if (k_idx_ff == '0) begin
                     lo_t_ff   <= '0;
                     lo_v_ff   <= '0;
                     k_st_ff   <= K_DONE;
                  end else begin
                     k_idx_ff <= k_idx_ff - IW'(1);
                     k_st_ff  <= K_LO;
                  end
               end else begin
                  k_idx_ff <= k_idx_ff + IW'(1);
                  k_st_ff  <= K_RD;
               end
            end
            K_LO: k_st_ff <= K_LOW;
            K_LOW: begin
               lo_t_ff <= rd_time_ff;
               lo_v_ff <= rd_val_ff;
               k_st_ff <= K_DONE;
            end
            K_DONE: begin
               k_done_ff <= 1'b1;
               k_st_ff   <= K_IDLE;
            end
            default: k_st_ff <= K_IDLE;
         endcase
      end
   end

   // Interpolation: multiply, then restoring divide of |num| + den/2 by den.
   typedef enum logic [2:0] {D_IDLE, D_MUL, D_PREP, D_RUN, D_OUT} dstate_type;
   dstate_type   d_st_ff;
   logic [31:0]  den_ff;       // hi_t - lo_t (may be negative for unordered)
   logic [31:0]  dt_ff;        // tr - lo_t
   logic [16:0]  dv_ff;        // hi_v - lo_v
   logic [48:0]  num_ff;       // signed product
   logic [48:0]  q_dvd_ff;
   logic [31:0]  q_rem_ff;
   logic [48:0]  quot_ff;
   logic [5:0]   d_cnt_ff;
   logic         num_neg_ff;
   logic         d_done_ff;
   logic [15:0]  value_ff;
   logic [32:0]  d_trial;
   logic [49:0]  sum_wide;
   logic signed [50:0] r_wide;

   assign d_trial = {q_rem_ff, q_dvd_ff[48]} - {1'b0, den_ff};
   assign r_wide  = 51'(signed'(lo_v_ff))
                  + (num_neg_ff ? -signed'({2'b0, quot_ff}) : signed'({2'b0, quot_ff}));
   // Rounded dividend: magnitude of the product plus half the divisor.
   assign sum_wide = {1'b0, (num_ff[48] ? -num_ff : num_ff)} + 50'(den_ff[31:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_st_ff   <= D_IDLE;
         d_done_ff <= 1'b0;
      end else begin
         d_done_ff <= 1'b0;
         unique case (d_st_ff)
            D_IDLE: if (ctl.div_start) d_st_ff <= D_MUL;
            D_MUL:  d_st_ff <= D_PREP;
            D_PREP: d_st_ff <= (den_ff[31] || den_ff == '0) ? D_OUT : D_RUN;
            D_RUN:  if (d_cnt_ff == 6'd48) d_st_ff <= D_OUT;
            D_OUT: begin
               d_st_ff   <= D_IDLE;
               d_done_ff <= 1'b1;
            end
            default: d_st_ff <= D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (d_st_ff)
         D_IDLE: if (ctl.div_start) begin
            den_ff <= {1'b0, hi_t_ff} - {1'b0, lo_t_ff};
            dt_ff  <= {1'b0, tr_ff} - {1'b0, lo_t_ff};
            dv_ff  <= 17'(signed'(hi_v_ff)) - 17'(signed'(lo_v_ff));
         end
         D_MUL: begin
            num_ff <= 49'(signed'(dt_ff) * signed'(dv_ff));
         end
         D_PREP: begin
            num_neg_ff <= num_ff[48];
            q_dvd_ff   <= sum_wide[48:0];
            q_rem_ff   <= '0;
            quot_ff    <= '0;
            d_cnt_ff   <= '0;
         end
         D_RUN: begin
            d_cnt_ff <= d_cnt_ff + 6'd1;
            q_dvd_ff <= {q_dvd_ff[47:0], 1'b0};
            if (!d_trial[32]) begin
               q_rem_ff <= d_trial[31:0];
               quot_ff  <= {quot_ff[47:0], 1'b1};
            end else begin
               q_rem_ff <= {q_rem_ff[30:0], q_dvd_ff[48]};
               quot_ff  <= {quot_ff[47:0], 1'b0};
            end
         end
         D_OUT: begin
            if (den_ff[31] || den_ff == '0)
               value_ff <= hi_v_ff;
            else if (r_wide > 51'sd32767)
               value_ff <= 16'h7FFF;
            else if (r_wide < -51'sd32768)
               value_ff <= 16'h8000;
            else
               value_ff <= r_wide[15:0];
         end
         default: ;
      endcase
   end

   // Result word.
   always_comb begin
      res_full  = (cmd_ff == pwl_pkg::CMD_APPEND);
      res_empty = !res_full && sts.is_empty;
      res_time  = res_full ? '0 : samp_ff;
      res_value = (res_full || sts.is_empty) ? '0 : value_ff;
   end

   assign sts.mod_done  = m_done_ff;
   assign sts.scan_done = k_done_ff;
   assign sts.div_done  = d_done_ff;

`ifndef SYNTHESIS
   // The point count never exceeds the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pwl_pkg::MAX_POINTS)) else $error("point count overflow");
   // The reduced time stays inside the period.
   a_tr_range: assert property (@(posedge clock) disable iff (reset)
      m_done_ff && period_ff != '0 |-> tr_ff < period_ff) else $error("reduction out of range");
   // Appends only happen with room in the table.
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      ctl.append |-> !sts.is_full) else $error("append to full table");
`endif

endmodule

// ----- rtl/pwl_periodic_waveform_generator_unit.sv -----
// Top level of the periodic piecewise-linear waveform generator.
// Depends on pwl_pkg, pwl_ctrl and pwl_datapath.
//
// Usage: command words enter on req_ (tdata packs command, point_time,
// point_value, time_in). Clear, append and start-sweep give no result.
// Sample and sweep-step give one result word on rsp_; an append to a full
// table gives one result with table_full set.
// A sample runs through the 32-step bit-serial modulo unit, a search of
// one breakpoint at a time through the table read port, and the 49-step
// restoring divider. A zero-length or reversed segment skips the divide;
// an empty table skips all three.
// One word is processed at a time; req_tready is high while idle.
// The result sits in an output register; a stalled rsp_tready holds it
// and the next word may still be accepted and worked on, stalling only at
// its own result.
// Reset clears the point count and sweep time and sets sweep_step to 1.0.
// The table contents are undefined until written.
`timescale 1ns / 1ps

module pwl_periodic_waveform_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [33:3] point_time, [49:34] point_value, [81:50] time_in
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] sample_time, [47:32] sample_value
   output logic [47:0] rsp_tdata,
   // [0] empty_error, [1] table_full
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pwl_pkg::ctl_type ctl;
   pwl_pkg::sts_type sts;
   logic [30:0] step_ff;
   logic [31:0] r_time;
   logic [15:0] r_value;
   logic        r_empty, r_full;
   logic        busy;
   logic [47:0] out_data_ff;
   logic [1:0]  out_user_ff;
   logic        out_valid_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == pwl_pkg::REG_SWEEP_STEP) ? {1'b0, step_ff} : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= pwl_pkg::SWEEP_STEP_RESET[30:0];
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == pwl_pkg::REG_SWEEP_STEP) begin
         step_ff <= csr_pwdata[30:0];
      end
   end

   assign busy = out_valid_ff && !rsp_tready;

   pwl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_cmd   (req_tdata[2:0]),
      .in_ready (req_tready),
      .out_busy (busy),
      .ctl      (ctl),
      .sts      (sts)
   );

   pwl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .in_cmd     (req_tdata[2:0]),
      .in_ptime   (req_tdata[33:3]),
      .in_pval    (req_tdata[49:34]),
      .in_time    (req_tdata[81:50]),
      .sweep_step (step_ff),
      .res_time   (r_time),
      .res_value  (r_value),
      .res_empty  (r_empty),
      .res_full   (r_full)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (ctl.finish) begin
         out_data_ff <= {r_value, r_time};
         out_user_ff <= {r_full, r_empty};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef SYNTHESIS
   // A held result keeps its word until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   // Never both error flags at once.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1])) else $error("both flags set");
   // A new result is never written over an untaken one.
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> !busy) else $error("result overwritten");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the periodic piecewise-linear waveform generator.
// Depends on pwl_pkg and the top level pwl_periodic_waveform_generator_unit.
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 20000;

   // Result word as seen on the rsp_ channel.
   typedef struct packed {
      logic [31:0] sample_time;
      logic [15:0] sample_value;
      logic        empty_error;
      logic        table_full;
   } wave_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pwl_periodic_waveform_generator_unit u_top (.*);

   always #4 clock = ~clock;

   // Shadow state of the waveform table.
   logic [30:0] shadow_times [pwl_pkg::MAX_POINTS];
   logic [15:0] shadow_values [pwl_pkg::MAX_POINTS];
   int unsigned shadow_count;
   logic [31:0] shadow_sweep_time;
   logic [30:0] shadow_step;

   wave_result_type expected_samples [$];
   int error_count = 0;
   int result_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
               result_count);
   endtask

   // Interpolated value at signed time t over the current table.
   function automatic logic [15:0] interpolate_value(input logic signed [31:0] t);
      longint period, tr, lo_t, lo_v, hi_t, hi_v, den, num, mag, q, r;
      int k;
      period = longint'(shadow_times[shadow_count-1]);
      tr = 0;
      lo_t = 0;
      lo_v = 0;
      k = shadow_count - 1;
      if (period > 0) begin
         tr = longint'(t) % period;
         if (tr < 0) tr += period;
      end
      for (int i = shadow_count - 1; i >= 0; i--)
         if (longint'(shadow_times[i]) >= tr) k = i;
      hi_t = longint'(shadow_times[k]);
      hi_v = longint'($signed(shadow_values[k]));
      if (k > 0) begin
         lo_t = longint'(shadow_times[k-1]);
         lo_v = longint'($signed(shadow_values[k-1]));
      end
      den = hi_t - lo_t;
      if (den <= 0) return hi_v[15:0];
      num = (tr - lo_t) * (hi_v - lo_v);
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      r = lo_v + q;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic wave_result_type sample_at(input logic [31:0] t);
      wave_result_type res;
      res = '0;
      res.sample_time = t;
      if (shadow_count == 0) res.empty_error = 1'b1;
      else res.sample_value = interpolate_value(t);
      return res;
   endfunction

   // Update the shadow state for one accepted word and queue any result.
   task automatic predict_word(input logic [2:0] cmd, input logic [30:0] ptime,
                               input logic [15:0] pval, input logic [31:0] tin);
      wave_result_type res;
      case (cmd)
         pwl_pkg::CMD_CLEAR: shadow_count = 0;
         pwl_pkg::CMD_APPEND: begin
            if (shadow_count >= pwl_pkg::MAX_POINTS) begin
               res = '0;
               res.table_full = 1'b1;
               expected_samples.push_back(res);
            end else begin
               shadow_times[shadow_count] = ptime;
               shadow_values[shadow_count] = pval;
               shadow_count++;
            end
         end
         pwl_pkg::CMD_SAMPLE: expected_samples.push_back(sample_at(tin));
         pwl_pkg::CMD_START: shadow_sweep_time = tin;
         pwl_pkg::CMD_STEP: begin
            expected_samples.push_back(sample_at(shadow_sweep_time));
            shadow_sweep_time = shadow_sweep_time + {1'b0, shadow_step};
         end
         default: ;
      endcase
   endtask

   // Send one word, honoring the sender idle rate. The valid stays high
   // after acceptance until the next word or an explicit release.
   task automatic send_word(input logic [2:0] cmd, input logic [30:0] ptime,
                            input logic [15:0] pval, input logic [31:0] tin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, tin, pval, ptime, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(cmd, ptime, pval, tin);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_step(input logic [30:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= pwl_pkg::REG_SWEEP_STEP;
      csr_pwdata <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      shadow_step = value;
   endtask

   // Receiver stall and result checking.
   always @(posedge clock) begin
      wave_result_type want;
      logic [47:0] got_data;
      got_data = rsp_tdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected word", got_data[31:0], '0);
         end else begin
            want = expected_samples.pop_front();
            if (got_data[31:0] !== want.sample_time)
               report_mismatch("sample_time", got_data[31:0], want.sample_time);
            if (got_data[47:32] !== want.sample_value)
               report_mismatch("sample_value", got_data[47:32], want.sample_value);
            if (rsp_tuser[0] !== want.empty_error)
               report_mismatch("empty_error", rsp_tuser[0], want.empty_error);
            if (rsp_tuser[1] !== want.table_full)
               report_mismatch("table_full", rsp_tuser[1], want.table_full);
         end
         result_count++;
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles with no accepted word on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", expected_samples.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic logic [31:0] random_time();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(255);
         default: return $urandom();
      endcase
   endfunction

   // Load an ascending table of n points with random content.
   task automatic load_table(input int n, input logic [30:0] max_gap);
      logic [30:0] t;
      t = $urandom_range(1) ? 31'd0 : 31'($urandom_range(max_gap));
      send_word(pwl_pkg::CMD_CLEAR, 31'($urandom()), 16'($urandom()), $urandom());
      for (int i = 0; i < n; i++) begin
         send_word(pwl_pkg::CMD_APPEND, t, 16'($urandom()), $urandom());
         t = t + ($urandom_range(5) == 0 ? 31'd0 : 31'($urandom_range(max_gap)));
      end
   endtask

   // Extremes of every field and each special case.
   task automatic test_directed();
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'h0001_0000);        // empty table
      send_word(pwl_pkg::CMD_STEP, '0, '0, '0);                      // empty sweep advances
      send_word(pwl_pkg::CMD_APPEND, '0, 16'h7fff, '0);             // zero-length from origin
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'h1234_5678);        // zero period
      send_word(pwl_pkg::CMD_APPEND, 31'h0001_0000, 16'h8000, '0);
      send_word(pwl_pkg::CMD_APPEND, 31'h0001_0000, 16'h7fff, '0);  // zero-length segment
      send_word(pwl_pkg::CMD_APPEND, 31'h7fff_ffff, 16'h8000, '1);
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'h8000_0000);
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'h7fff_ffff);
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'hffff_ffff);
      send_word(pwl_pkg::CMD_APPEND, 31'h0000_8000, 16'h1234, '0);  // out of order
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'h0000_c000);
      send_word(3'd5, '1, '1, '1);                                   // unused codes
      send_word(3'd6, '0, '0, '0);
      send_word(3'd7, '1, '0, '1);
      send_word(pwl_pkg::CMD_START, '0, '0, 32'h7fff_0000);
      send_word(pwl_pkg::CMD_STEP, '0, '0, '0);
      send_word(pwl_pkg::CMD_STEP, '0, '0, '0);
      for (int i = 0; i < 13; i++)
         send_word(pwl_pkg::CMD_APPEND, '1, 16'($urandom()), '0);
      send_word(pwl_pkg::CMD_SAMPLE, '0, '0, 32'h0000_4000);
   endtask

   // Mostly well-formed tables with samples and sweeps, plus noise.
   task automatic test_random(input int count);
      int n;
      while (count > 0) begin
         n = $urandom_range(7) == 0 ? pwl_pkg::MAX_POINTS : $urandom_range(1, 6);
         load_table(n, $urandom_range(1) ? 31'h0004_0000 : 31'h07ff_ffff);
         count -= n + 1;
         if ($urandom_range(3) == 0) begin
            send_word(pwl_pkg::CMD_APPEND, 31'($urandom()), 16'($urandom()), $urandom());
            count--;
         end
         send_word(pwl_pkg::CMD_START, '0, '0, random_time());
         count--;
         for (int i = $urandom_range(2, 6); i > 0; i--) begin
            case ($urandom_range(9))
               0: send_word(3'($urandom_range(5, 7)), 31'($urandom()), 16'($urandom()),
                            $urandom());
               1, 2, 3: send_word(pwl_pkg::CMD_STEP, 31'($urandom()), 16'($urandom()),
                                  $urandom());
               default: send_word(pwl_pkg::CMD_SAMPLE, 31'($urandom()), 16'($urandom()),
                                  random_time());
            endcase
            count--;
         end
      end
   endtask

   // Several sweep steps, extremes among them, each written while idle.
   task automatic test_sweep_steps();
      logic [30:0] steps [4] = '{31'd0, 31'h7fff_ffff, 31'h0000_4000, 31'h5555_aaaa};
      foreach (steps[i]) begin
         wait_drained();
         write_step(steps[i]);
         test_random(60);
      end
   endtask

   initial begin
      for (int i = 0; i < pwl_pkg::MAX_POINTS; i++) begin
         shadow_times[i] = '0;
         shadow_values[i] = '0;
      end
      shadow_count = 0;
      shadow_sweep_time = '0;
      shadow_step = pwl_pkg::SWEEP_STEP_RESET[30:0];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 8;
      recv_idle_pct = 47;
      test_random(500);
      // Hold off the sender until the block has delivered everything.
      wait_drained();
      send_idle_pct = 47;
      recv_idle_pct = 8;
      test_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_sweep_steps();
      test_random(300);
      wait_drained();
      $display("Sent %0d words and checked %0d results over table, sample,", items_sent,
               result_count);
      $display("sweep, full and empty cases with several sweep step settings.");
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pwl_pkg.sv
rtl/pwl_ctrl.sv
rtl/pwl_datapath.sv
rtl/pwl_periodic_waveform_generator_unit.sv
tb/testbench.sv
